// File: sv/aes_pkg.sv
// AES block cipher package: item types, S-box functions, round helpers.
// Used by every module of the cipher; depends on nothing.
package aes_pkg;

    localparam int unsigned KeyStoreWords = 60;

    typedef struct packed {
        logic        operation;
        logic [63:0] block_high;
        logic [63:0] block_low;
    } in_item_t;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } out_item_t;

    // configuration register indexes
    localparam logic [2:0] REG_KEY_SIZE = 3'd0;
    localparam logic [2:0] REG_KEY_W0   = 3'd1;
    localparam logic [2:0] REG_KEY_W1   = 3'd2;
    localparam logic [2:0] REG_KEY_W2   = 3'd3;
    localparam logic [2:0] REG_KEY_W3   = 3'd4;

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        logic [7:0] x;
        r = 8'h00;
        x = a;
        for (int k = 0; k < 8; k++)
        begin
            if (b[k])
                r = r ^ x;
            x = xtime(x);
        end
        gmul = r;
    endfunction

    // x^254 by square and multiply; elaborates to a constant table per use
    function automatic logic [7:0] ginv(input logic [7:0] x);
        logic [7:0] r;
        logic [7:0] b;
        r = 8'h01;
        b = x;
        for (int e = 1; e < 8; e++)
        begin
            b = gmul(b, b);
            r = gmul(r, b);
        end
        ginv = r;
    endfunction

    function automatic logic [7:0] rotl8(input logic [7:0] v, input int n);
        rotl8 = (v << n) | (v >> (8 - n));
    endfunction

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] b;
        b = ginv(x);
        sbox = b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4) ^ 8'h63;
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] s);
        inv_sbox = ginv(rotl8(s, 1) ^ rotl8(s, 3) ^ rotl8(s, 6) ^ 8'h05);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

endpackage

// File: sv/aes_key_exp.sv
// Key expansion: one round key word per cycle into the round key memory.
// Depends on aes_pkg. Read port gives four words (one round key) registered.
module aes_key_exp
    import aes_pkg::*;
#(
    parameter int unsigned STORE_WORDS = KeyStoreWords
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [1:0]                     key_size,
    input  logic [255:0]                   key,
    output logic                           busy,
    output logic [3:0]                     rounds,
    input  logic [$clog2(STORE_WORDS/4)-1:0] rd_round,
    output logic [127:0]                   rd_key
);

    localparam int unsigned RowCount = STORE_WORDS / 4;
    localparam int unsigned WordBits = $clog2(STORE_WORDS + 1);

    // one row holds the four words of a round key, written word by word
    logic [31:0] mem0 [RowCount];
    logic [31:0] mem1 [RowCount];
    logic [31:0] mem2 [RowCount];
    logic [31:0] mem3 [RowCount];

    logic [WordBits-1:0] idx_reg;
    logic [WordBits-1:0] total_reg;
    logic [3:0]          nk_reg;
    logic [3:0]          rounds_reg;
    logic [3:0]          cnt_reg;      // i mod nk
    logic [7:0]          rcon_reg;
    logic                busy_reg;
    logic [255:0]        win_reg;      // last eight words, newest in low bits
    logic [1:0]          sel;
    logic [3:0]          nk_next;
    logic [31:0]         prev_w;
    logic [31:0]         back_w;
    logic [31:0]         t;
    logic [31:0]         new_w;

    // take the requested key size, or the largest that fits the store if it does not fit
    always_comb
    begin
        sel = (key_size == 2'd3) ? 2'd2 : key_size;
        if (sel == 2'd2 && STORE_WORDS < 60)
            sel = 2'd1;
        if (sel == 2'd1 && STORE_WORDS < 52)
            sel = 2'd0;
        nk_next = 4'd4 + {1'b0, sel, 1'b0};
    end

    assign prev_w = win_reg[31:0];
    always_comb
    begin
        case (nk_reg)
            4'd4:    back_w = win_reg[127:96];
            4'd6:    back_w = win_reg[191:160];
            default: back_w = win_reg[255:224];
        endcase
        t = prev_w;
        if (cnt_reg == 4'd0)
            t = sub_word({prev_w[23:0], prev_w[31:24]}) ^ {rcon_reg, 24'h0};
        else if (nk_reg == 4'd8 && cnt_reg == 4'd4)
            t = sub_word(prev_w);
        new_w = (idx_reg < WordBits'(nk_reg)) ? win_reg[255:224] : (t ^ back_w);
    end

    // sequencer for the expansion
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            idx_reg    <= '0;
            total_reg  <= '0;
            nk_reg     <= 4'd4;
            rounds_reg <= 4'd10;
            cnt_reg    <= '0;
            rcon_reg   <= 8'h01;
        end
        else if (start)
        begin
            busy_reg   <= 1'b1;
            idx_reg    <= '0;
            nk_reg     <= nk_next;
            rounds_reg <= 4'd10 + {1'b0, sel, 1'b0};
            total_reg  <= WordBits'((11 + 2 * sel) * 4);
            cnt_reg    <= '0;
            rcon_reg   <= 8'h01;
        end
        else if (busy_reg)
        begin
            idx_reg <= idx_reg + 1'b1;
            if (idx_reg >= WordBits'(nk_reg))
            begin
                cnt_reg <= (cnt_reg == nk_reg - 4'd1) ? 4'd0 : cnt_reg + 4'd1;
                if (cnt_reg == 4'd0)
                    rcon_reg <= xtime(rcon_reg);
            end
            if (idx_reg == total_reg - 1'b1)
                busy_reg <= 1'b0;
        end
    end

    // key words shift in from the top during loading, then new words follow
    always_ff @(posedge clk)
    begin
        if (start)
            win_reg <= key;
        else if (busy_reg)
        begin
            if (idx_reg < WordBits'(nk_reg))
                win_reg <= {win_reg[223:0], new_w};
            else
                win_reg <= {win_reg[223:0], new_w};
        end
    end

    // memory write and registered row read
    always_ff @(posedge clk)
    begin
        if (busy_reg && idx_reg < WordBits'(STORE_WORDS))
        begin
            case (idx_reg[1:0])
                2'd0:    mem0[idx_reg[WordBits-1:2]] <= new_w;
                2'd1:    mem1[idx_reg[WordBits-1:2]] <= new_w;
                2'd2:    mem2[idx_reg[WordBits-1:2]] <= new_w;
                default: mem3[idx_reg[WordBits-1:2]] <= new_w;
            endcase
        end
        rd_key <= {mem0[rd_round], mem1[rd_round], mem2[rd_round], mem3[rd_round]};
    end

    assign busy   = busy_reg;
    assign rounds = rounds_reg;

endmodule

// File: sv/aes_round.sv
// Shared AES round unit: one forward or inverse round, combinational.
// Depends on aes_pkg.
module aes_round
    import aes_pkg::*;
(
    input  logic [127:0] state_in,
    input  logic [127:0] round_key,
    input  logic         inverse,
    input  logic         first,
    input  logic         last,
    output logic [127:0] state_out
);

    logic [7:0] s [16];
    logic [7:0] a [16];
    logic [7:0] b [16];
    logic [7:0] m [16];
    logic [7:0] k [16];

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            s[i] = state_in[127 - 8 * i -: 8];
            k[i] = round_key[127 - 8 * i -: 8];
        end
        // substitution with row shift
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
            begin
                if (inverse)
                    a[r + 4 * ((c + r) % 4)] = inv_sbox(s[r + 4 * c]);
                else
                    a[r + 4 * c] = sbox(s[r + 4 * ((c + r) % 4)]);
            end
        // inverse round adds the key before column mixing
        for (int i = 0; i < 16; i++)
            b[i] = inverse ? (a[i] ^ k[i]) : a[i];
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
            begin
                if (inverse)
                    m[4 * c + r] = gmul(b[4 * c + r], 8'h0e)
                                 ^ gmul(b[4 * c + (r + 1) % 4], 8'h0b)
                                 ^ gmul(b[4 * c + (r + 2) % 4], 8'h0d)
                                 ^ gmul(b[4 * c + (r + 3) % 4], 8'h09);
                else
                    m[4 * c + r] = xtime(b[4 * c + r])
                                 ^ xtime(b[4 * c + (r + 1) % 4]) ^ b[4 * c + (r + 1) % 4]
                                 ^ b[4 * c + (r + 2) % 4] ^ b[4 * c + (r + 3) % 4];
            end
        for (int i = 0; i < 16; i++)
        begin
            if (first)
                state_out[127 - 8 * i -: 8] = s[i] ^ k[i];
            else if (last)
                state_out[127 - 8 * i -: 8] = inverse ? b[i] : (a[i] ^ k[i]);
            else
                state_out[127 - 8 * i -: 8] = inverse ? m[i] : (m[i] ^ k[i]);
        end
    end

endmodule

// File: sv/aes_block_cipher_unit.sv
// AES-128/192/256 block cipher, one round per cycle through a shared round unit.
// Each item goes through a fetch state that adds the first round key, the rounds and
// a done state; the first item after reset or a key or key-size write waits first
// for key expansion. No new item is taken until the unit is idle again; a waiting
// result holds the unit in its done state only when the next one is ready to leave.
// Reset: asynchronous active low; key registers cleared to zero, keys not ready.
module aes_block_cipher_unit
    import aes_pkg::*;
#(
    parameter int unsigned KEY_STORE_WORDS = KeyStoreWords
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_item,
    input  logic      cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int unsigned RoundBits = $clog2(KEY_STORE_WORDS / 4);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_KEYS  = 5'b00010,
        ST_FETCH = 5'b00100,
        ST_ROUND = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [1:0]   key_size_reg;
    logic [255:0] key_reg;
    logic         ready_reg;
    logic         op_reg;
    logic [127:0] data_reg;
    logic [3:0]   step_reg;      // rounds done
    logic         out_valid_reg;
    out_item_t    out_reg;
    logic         kx_start;
    logic         kx_busy;
    logic [3:0]   rounds;
    logic [RoundBits-1:0] rd_round;
    logic [127:0] rd_key;
    logic [127:0] round_out;
    logic [3:0]   want;
    logic         op_sel;
    logic         out_free;
    logic         accept;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign kx_start = accept && !ready_reg;
    assign out_free = !out_valid_reg || !out_stall;

    aes_key_exp #(.STORE_WORDS(KEY_STORE_WORDS)) u_key_exp (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (kx_start),
        .key_size (key_size_reg),
        .key      (key_reg),
        .busy     (kx_busy),
        .rounds   (rounds),
        .rd_round (rd_round),
        .rd_key   (rd_key)
    );

    // round keys are read through a register, in the cycle before the round that uses them
    always_comb
    begin
        op_sel = (state_reg == ST_IDLE) ? in_item.operation : op_reg;
        case (state_reg)
            ST_FETCH: want = 4'd1;
            ST_ROUND: want = (step_reg == rounds - 4'd1) ? 4'd0 : step_reg + 4'd2;
            default:  want = 4'd0;
        endcase
        rd_round = RoundBits'(op_sel ? rounds - want : want);
    end

    aes_round u_round (
        .state_in  (data_reg),
        .round_key (rd_key),
        .inverse   (op_reg),
        .first     (state_reg == ST_FETCH),
        .last      (step_reg == rounds - 4'd1),
        .state_out (round_out)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (accept) state_next = ready_reg ? ST_FETCH : ST_KEYS;
            ST_KEYS:  if (!kx_busy) state_next = ST_FETCH;
            ST_FETCH: state_next = ST_ROUND;
            ST_ROUND: if (step_reg == rounds - 4'd1) state_next = ST_DONE;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // control and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            key_size_reg  <= '0;
            key_reg       <= '0;
            ready_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (kx_start)
                ready_reg <= 1'b1;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_KEY_SIZE: key_size_reg <= cfg_data[1:0];
                    REG_KEY_W0:   key_reg[255:192] <= cfg_data;
                    REG_KEY_W1:   key_reg[191:128] <= cfg_data;
                    REG_KEY_W2:   key_reg[127:64]  <= cfg_data;
                    REG_KEY_W3:   key_reg[63:0]    <= cfg_data;
                    default: ;
                endcase
                if (cfg_index <= REG_KEY_W3)
                    ready_reg <= 1'b0;
            end
            if (state_reg == ST_FETCH)
                step_reg <= '0;
            else if (state_reg == ST_ROUND)
                step_reg <= step_reg + 4'd1;
            if (state_reg == ST_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // data path
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= in_item.operation;
            data_reg <= {in_item.block_high, in_item.block_low};
        end
        else if (state_reg == ST_FETCH || state_reg == ST_ROUND)
            data_reg <= round_out;
        if (state_reg == ST_DONE && out_free)
            out_reg <= {data_reg[127:64], data_reg[63:0]};
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !accept) else $error("item taken while busy");
    a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |=> out_valid) else $error("result lost");
    a_keys_first: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FETCH) |-> !kx_busy) else $error("round before keys");

endmodule
